>>> hdl/cls_pkg.sv
// ============================================================================
// cls_pkg
// Shared codes, defaults and controller/datapath link types for the
// circular list store.
// ============================================================================
`default_nettype none

package cls_pkg;

    localparam int CAPACITY = 16;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 3;
    localparam int STEP_W  = 5;
    localparam int ENT_W   = 5;

    // input commands
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_ELEMENT  = 3'd4;

    // write address select
    localparam logic [1:0] WR_HEAD = 2'd0;  // slot before the current head
    localparam logic [1:0] WR_TAIL = 2'd1;  // slot after the current tail
    localparam logic [1:0] WR_IDX  = 2'd2;  // slot at the working index

    typedef struct packed {
        logic              acc;       // input may be taken this cycle
        logic              rd_en;     // read ring at working index + rd_off
        logic [1:0]        rd_off;
        logic              idx_inc;
        logic              wr_en;
        logic [1:0]        wr_sel;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              set_st;
        logic [STAT_W-1:0] st;
        logic              out_load;
        logic              out_elem;  // element beat rather than a response
    } t_ctl_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cnt_zero;
        logic             full;
        logic             match;      // read data equals the key
        logic             idx_last;   // working index is the tail
        logic             shift_last; // working index is one before the tail
        logic             out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/cls_in_if.sv
// ============================================================================
// cls_in_if
// Command channel: valid/ready handshake carrying command and value.
// ============================================================================
`default_nettype none

interface cls_in_if;
    logic                                valid;
    logic                                ready;
    logic        [cls_pkg::CMD_W-1:0]    command;
    logic signed [cls_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

>>> hdl/cls_out_if.sv
// ============================================================================
// cls_out_if
// Result channel: valid/ready handshake carrying one result beat.
// ============================================================================
`default_nettype none

interface cls_out_if;
    logic                                valid;
    logic                                ready;
    logic        [cls_pkg::STAT_W-1:0]   status;
    logic signed [cls_pkg::VALUE_W-1:0]  element;
    logic        [cls_pkg::STEP_W-1:0]   step;
    logic        [cls_pkg::ENT_W-1:0]    entries;
    logic                                last;

    modport source (output valid, output status, output element, output step,
                    output entries, output last, input ready);
    modport sink   (input valid, input status, input element, input step,
                    input entries, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/cls_datapath.sv
// ============================================================================
// cls_datapath
// Ring memory with head pointer and count, working index, key register and
// the output register.
// ============================================================================
`default_nettype none

module cls_datapath #(
    parameter int CAPACITY = cls_pkg::CAPACITY
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  cls_pkg::t_ctl_cmd                   i_cmd,
    output cls_pkg::t_dp_sts                    o_sts,
    input  wire                                 i_in_valid,
    input  wire        [cls_pkg::CMD_W-1:0]     i_in_command,
    input  wire signed [cls_pkg::VALUE_W-1:0]   i_in_value,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic       [cls_pkg::STAT_W-1:0]    o_out_status,
    output logic signed [cls_pkg::VALUE_W-1:0]  o_out_element,
    output logic       [cls_pkg::STEP_W-1:0]    o_out_step,
    output logic       [cls_pkg::ENT_W-1:0]     o_out_entries,
    output logic                                o_out_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

    logic [cls_pkg::VALUE_W-1:0] r_mem [CAPACITY];
    logic [cls_pkg::VALUE_W-1:0] r_rd_data;

    logic [AW-1:0]               r_head, n_head;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_idx;
    logic [cls_pkg::CMD_W-1:0]   r_cmd;
    logic [cls_pkg::VALUE_W-1:0] r_val;
    logic [cls_pkg::STAT_W-1:0]  r_status;

    logic                        r_out_valid;
    logic [cls_pkg::STAT_W-1:0]  r_out_status;
    logic [cls_pkg::VALUE_W-1:0] r_out_element;
    logic [cls_pkg::STEP_W-1:0]  r_out_step;
    logic [cls_pkg::ENT_W-1:0]   r_out_entries;
    logic                        r_out_last;

    logic                        out_free;
    logic [AW-1:0]               head_prev;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [cls_pkg::VALUE_W-1:0] wr_data;
    logic [CW-1:0]               idx_p1;
    logic [SW-1:0]               idx_p2;

    // logical position -> physical slot, one compare-subtract wrap
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [SW-1:0] pos);
        logic [SW-1:0] sum;
        sum = SW'(head) + pos;
        if (sum >= CAP_S) begin
            sum = sum - CAP_S;
        end
        return sum[AW-1:0];
    endfunction

    assign out_free  = !r_out_valid || i_out_ready;
    assign head_prev = (r_head == '0) ? LAST_A : r_head - 1'b1;
    assign idx_p1    = r_idx + 1'b1;
    assign idx_p2    = SW'(r_idx) + SW'(2);

    assign rd_addr = phys(r_head, SW'(r_idx) + SW'(i_cmd.rd_off));

    always_comb begin
        case (i_cmd.wr_sel)
            cls_pkg::WR_HEAD: begin
                wr_addr = head_prev;
                wr_data = r_val;
            end
            cls_pkg::WR_TAIL: begin
                wr_addr = phys(r_head, SW'(r_count));
                wr_data = r_val;
            end
            default: begin
                wr_addr = phys(r_head, SW'(r_idx));
                wr_data = r_rd_data;
            end
        endcase
    end

    // ring memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_head = r_head;
        if (i_cmd.wr_en && i_cmd.wr_sel == cls_pkg::WR_HEAD) begin
            n_head = head_prev;
        end
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && i_in_valid) begin
            r_cmd <= i_in_command;
            r_val <= i_in_value;
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_p1;
        end
        if (i_cmd.set_st) begin
            r_status <= i_cmd.st;
        end
        if (i_cmd.out_load) begin
            r_out_entries <= cls_pkg::ENT_W'(r_count);
            if (i_cmd.out_elem) begin
                r_out_status  <= cls_pkg::ST_ELEMENT;
                r_out_element <= r_rd_data;
                r_out_step    <= cls_pkg::STEP_W'(idx_p1);
                r_out_last    <= (idx_p1 == r_count);
            end else begin
                r_out_status  <= r_status;
                r_out_element <= r_val;
                r_out_step    <= '0;
                r_out_last    <= 1'b1;
            end
        end
    end

    assign o_sts.cmd        = r_cmd;
    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.full       = (SW'(r_count) >= CAP_S);
    assign o_sts.match      = (r_rd_data == r_val);
    assign o_sts.idx_last   = (idx_p1 == r_count);
    assign o_sts.shift_last = (idx_p2 == SW'(r_count));
    assign o_sts.out_free   = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_out_status  = r_out_status;
    assign o_out_element = r_out_element;
    assign o_out_step    = r_out_step;
    assign o_out_entries = r_out_entries;
    assign o_out_last    = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_count) <= CAP_S)
        else $error("entry count above capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register loaded while a beat is pending");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (SW'(r_count) < CAP_S) && i_cmd.wr_en)
        else $error("insert into a full ring");

    a_delete_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |=> r_count == $past(r_count) - 1'b1)
        else $error("delete did not reduce the count by one");

endmodule

`default_nettype wire

>>> hdl/cls_ctrl.sv
// ============================================================================
// cls_ctrl
// Sequencer: decodes the held command and steps the datapath through
// insert, search/shift and traverse.
// ============================================================================
`default_nettype none

module cls_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  cls_pkg::t_dp_sts    i_sts,
    output cls_pkg::t_ctl_cmd   o_cmd,
    output logic                o_in_ready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_TRV    = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.acc = 1'b1;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_st = 1'b1;
                n_state      = S_RESP;
                case (i_sts.cmd)
                    cls_pkg::CMD_INS_HEAD, cls_pkg::CMD_INS_TAIL: begin
                        if (i_sts.full) begin
                            o_cmd.st = cls_pkg::ST_FULL;
                        end else begin
                            o_cmd.st      = cls_pkg::ST_DONE;
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = (i_sts.cmd == cls_pkg::CMD_INS_HEAD) ?
                                            cls_pkg::WR_HEAD : cls_pkg::WR_TAIL;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    cls_pkg::CMD_DELETE: begin
                        o_cmd.st = cls_pkg::ST_EMPTY;
                        if (!i_sts.cnt_zero) begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.st = cls_pkg::ST_EMPTY;
                        if (!i_sts.cnt_zero) begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_TRV;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.match) begin
                    if (i_sts.idx_last) begin
                        o_cmd.cnt_dec = 1'b1;
                        o_cmd.set_st  = 1'b1;
                        o_cmd.st      = cls_pkg::ST_DONE;
                        n_state       = S_RESP;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_off = 2'd1;
                        n_state      = S_SHIFT;
                    end
                end else if (i_sts.idx_last) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = cls_pkg::ST_NOTFOUND;
                    n_state      = S_RESP;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_off  = 2'd1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT: begin
                // pull the follower down one slot
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = cls_pkg::WR_IDX;
                if (i_sts.shift_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.set_st  = 1'b1;
                    o_cmd.st      = cls_pkg::ST_DONE;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_off  = 2'd2;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_TRV: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_elem = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_off  = 2'd1;
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (r_state == S_TRV) || (r_state == S_RESP))
        else $error("result loaded outside an emitting state");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && i_in_valid |=> r_state == S_DECODE)
        else $error("accepted command not decoded");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en && o_cmd.rd_en |-> o_cmd.rd_off == 2'd2)
        else $error("read and write at the same slot");

endmodule

`default_nettype wire

>>> hdl/circular_list_store_top.sv
// Flow: an insert or any status-only result passes the decode and response states
//   before it is valid; a delete also searches for the key and may shift later
//   entries down; a traverse gives one element beat a cycle while output is free.
// Commands: one at a time; a new one is taken only once the sequencer is idle.
// Reset: synchronous, active low; empties the ring at once, no clearing pass.
// ============================================================================
// circular_list_store_top
// Ordered ring of signed words with insert-at-head, insert-at-tail,
// delete-first-match and traverse commands.
// ============================================================================
`default_nettype none

module circular_list_store_top #(
    parameter int CAPACITY = cls_pkg::CAPACITY
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    cls_in_if.sink      i_in,
    cls_out_if.source   o_out
);

    // Structure
    //   cls_ctrl     : state machine; takes one command beat, then issues
    //                  memory reads/writes and result loads as commands.
    //   cls_datapath : ring memory addressed as head + logical position,
    //                  count, working index, key and the output register.
    //
    // The ring is kept in place: inserting at the head steps the head
    // pointer back, inserting at the tail writes just past the last entry.
    // A delete walks from the head comparing each read word with the key;
    // on a hit every later entry is copied one slot towards the head,
    // one read and one write per cycle, and the count drops by one.
    // A traverse reads one entry a cycle and hands each to the output
    // register, stalling while the previous beat is still held.
    //
    // The output register decouples the sides: a new command is taken as
    // soon as the sequencer is idle, even with the final beat unconsumed.

    cls_pkg::t_ctl_cmd s_cmd;
    cls_pkg::t_dp_sts  s_sts;
    logic              s_in_ready;

    cls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd),
        .o_in_ready (s_in_ready)
    );

    cls_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .o_sts         (s_sts),
        .i_in_valid    (i_in.valid),
        .i_in_command  (i_in.command),
        .i_in_value    (i_in.value),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_status  (o_out.status),
        .o_out_element (o_out.element),
        .o_out_step    (o_out.step),
        .o_out_entries (o_out.entries),
        .o_out_last    (o_out.last)
    );

    assign i_in.ready = s_in_ready;

endmodule

`default_nettype wire
